FILE: hw/rtl/bphr_pkg.sv
// ----------------------------------------------------------------------------
// Button press/hold/release package
// Shared widths, reset values, register indexes, status codes and beat types.
// ----------------------------------------------------------------------------
package bphr_pkg;

  // Fixed field widths
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 2;

  // Default width of the internal time arithmetic
  localparam int TIME_WIDTH_DEF = 32;

  // Register reset values
  localparam logic              ACTIVE_LEVEL_RST = 1'b1;
  localparam logic [DATA_W-1:0] HOLD_TIME_RST    = 32'd500;
  localparam logic [DATA_W-1:0] INTERVAL_RST     = 32'd0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_INTERVAL = 2'd2;

  // Reported status codes
  typedef enum logic [1:0] {
    ST_WAITING  = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_HELD     = 2'd2,
    ST_RELEASED = 2'd3
  } status_t;

  // One input beat
  typedef struct packed {
    logic              level;
    logic [DATA_W-1:0] now;
  } item_t;

  // One result beat
  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] held;
  } result_t;

endpackage

FILE: hw/rtl/button_press_hold_release_core.sv
// An accepted beat waits in the input register and moves on to the result
// register when that register has space. Throughput: one beat per cycle
// while the result side does not stall; the single evaluation stage updates
// the detector state as each beat moves from the input to the result register.
// Reset (synchronous, active high) empties both registers, restores the
// register defaults and returns the detector to released with zeroed stamps.
// ----------------------------------------------------------------------------
// Button press/hold/release core
// Debounced press, long-press and release detector on timestamped samples.
// ----------------------------------------------------------------------------
module button_press_hold_release_core #(
  parameter int TIME_WIDTH = bphr_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           level,
  input  logic [bphr_pkg::DATA_W-1:0]    now,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     status,
  output logic [bphr_pkg::DATA_W-1:0]    held_ticks,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bphr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bphr_pkg::DATA_W-1:0]    cfg_data
);
  import bphr_pkg::*;

  item_t   in_item;
  item_t   r_item;
  result_t result;
  result_t r_result;
  logic    r_valid;
  logic    space;
  logic    take;

  // Configuration beats are always taken.
  assign cfg_ready = 1'b1;

  assign in_item.level = level;
  assign in_item.now   = now;

  // A beat advances when the result register can take it.
  assign take = r_valid && space;

  bphr_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (take),
    .r_valid  (r_valid),
    .r_item   (r_item)
  );

  bphr_eval #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_eval (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .r_item    (r_item),
    .result    (result)
  );

  bphr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .result    (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .r_result  (r_result)
  );

  assign status     = 2'(r_result.status);
  assign held_ticks = r_result.held;

`ifndef SYNTHESIS
  // The input side only stalls while a beat is waiting in the input register.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> r_valid)
    else $error("input stalled with an empty input register");

  // Every beat that advances shows up as a valid result.
  a_take_result: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("advanced beat did not reach the result register");

  // A waiting beat is kept while the result side is stalled.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    r_valid && out_valid && !out_ready |=> r_valid)
    else $error("input beat lost during an output stall");

  // A release always clears the held duration.
  a_release_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (r_result.status == ST_RELEASED) |-> (held_ticks == '0))
    else $error("released reported with a nonzero held duration");
`endif

endmodule

FILE: hw/rtl/bphr_in_reg.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted input beat until the evaluation stage takes it.
// ----------------------------------------------------------------------------
module bphr_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bphr_pkg::item_t in_item,
  input  logic            take,
  output logic            r_valid,
  output bphr_pkg::item_t r_item
);
  import bphr_pkg::*;

  // A new beat may enter when the register is empty or is being drained.
  assign in_ready = !r_valid || take;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (in_ready) begin
      r_valid <= in_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      r_item <= in_item;
    end
  end

endmodule

FILE: hw/rtl/bphr_eval.sv
// ----------------------------------------------------------------------------
// Evaluation stage
// Configuration registers, detector state and the per-beat next-state logic.
// ----------------------------------------------------------------------------
module bphr_eval #(
  parameter int TIME_WIDTH = bphr_pkg::TIME_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [bphr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bphr_pkg::DATA_W-1:0]         cfg_data,
  input  logic                                take,
  input  bphr_pkg::item_t                     r_item,
  output bphr_pkg::result_t                   result
);
  import bphr_pkg::*;

  localparam int TW = TIME_WIDTH;

  // Configuration registers
  logic              active_level;
  logic [DATA_W-1:0] hold_time;
  logic [DATA_W-1:0] debounce_interval;

  // Detector state
  logic          is_pressed;
  logic [TW-1:0] press_stamp;
  logic [TW-1:0] debounce_stamp;
  logic [TW-1:0] held_count;

  logic          is_pressed_next;
  logic [TW-1:0] press_stamp_next;
  logic [TW-1:0] debounce_stamp_next;
  logic [TW-1:0] held_count_next;
  status_t       status_next;

  // Intermediate terms
  logic          active;
  logic          press_new;
  logic          pressed_a;
  logic [TW-1:0] now_w;
  logic [TW-1:0] interval_w;
  logic [TW-1:0] threshold;
  logic [TW-1:0] pstamp_a;
  logic [TW-1:0] pstamp_b;
  logic [TW-1:0] elapsed;
  logic [TW-1:0] held_calc;
  logic          expired;

  // Time values at the internal width, all arithmetic modulo 2^TW.
  assign now_w      = TW'(r_item.now);
  assign interval_w = TW'(debounce_interval);
  assign threshold  = TW'(hold_time) - interval_w;

  // Press detection and the stamps as they stand after a press.
  assign active              = (r_item.level == active_level);
  assign press_new           = active && !is_pressed;
  assign pressed_a           = is_pressed || press_new;
  assign debounce_stamp_next = press_new ? now_w : debounce_stamp;
  assign pstamp_a            = press_new ? now_w : press_stamp;

  // Debounce window and held duration, with the stamp zeroed on wrap.
  assign elapsed   = now_w - debounce_stamp_next;
  assign expired   = (elapsed >= interval_w);
  assign pstamp_b  = (now_w < pstamp_a) ? '0 : pstamp_a;
  assign held_calc = now_w - pstamp_b;

  // Status and state update for the beat in the input register.
  always_comb begin
    status_next      = press_new ? ST_PRESSED : ST_WAITING;
    held_count_next  = held_count;
    is_pressed_next  = pressed_a;
    press_stamp_next = pstamp_a;
    if (expired) begin
      held_count_next = '0;
      if (active && pressed_a) begin
        press_stamp_next = pstamp_b;
        held_count_next  = held_calc;
        if (held_calc >= threshold) begin
          status_next = ST_HELD;
        end
      end
      if (!active && pressed_a) begin
        status_next     = ST_RELEASED;
        is_pressed_next = 1'b0;
      end
    end
  end

  assign result.status = status_next;
  assign result.held   = DATA_W'(held_count_next);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_level      <= ACTIVE_LEVEL_RST;
      hold_time         <= HOLD_TIME_RST;
      debounce_interval <= INTERVAL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ACTIVE_LEVEL:      active_level      <= cfg_data[0];
        REG_HOLD_TIME:         hold_time         <= cfg_data;
        REG_DEBOUNCE_INTERVAL: debounce_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  // Detector state; rewriting the active level forgets any press.
  always_ff @(posedge clk) begin
    if (rst) begin
      is_pressed     <= 1'b0;
      press_stamp    <= '0;
      debounce_stamp <= '0;
      held_count     <= '0;
    end else begin
      if (cfg_valid && (cfg_index == REG_ACTIVE_LEVEL)) begin
        is_pressed <= 1'b0;
      end else if (take) begin
        is_pressed <= is_pressed_next;
      end
      if (take) begin
        press_stamp    <= press_stamp_next;
        debounce_stamp <= debounce_stamp_next;
        held_count     <= held_count_next;
      end
    end
  end

endmodule

FILE: hw/rtl/bphr_out_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module bphr_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  bphr_pkg::result_t result,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output bphr_pkg::result_t r_result
);
  import bphr_pkg::*;

  // The register can take a beat when empty or being emptied.
  assign space = !out_valid || out_ready;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      r_result <= result;
    end
  end

endmodule

FILE: sim/button_press_hold_release_core_tb.sv
// ----------------------------------------------------------------------------
// Button press/hold/release core testbench
// Drives timestamped pin samples and register writes under random idling and
// back-pressure, predicts each status beat and compares it as it arrives.
// ----------------------------------------------------------------------------
import bphr_pkg::*;

// Tracks the detector state and the status beats still owed by the core.
class detector_scoreboard;
  logic              act_level;
  logic [DATA_W-1:0] hold_ticks;
  logic [DATA_W-1:0] settle_ticks;
  bit                pressed;
  logic [DATA_W-1:0] press_at;
  logic [DATA_W-1:0] settle_from;
  logic [DATA_W-1:0] held_now;
  result_t           due_q[$];
  int unsigned       fails;

  function new();
    act_level    = ACTIVE_LEVEL_RST;
    hold_ticks   = HOLD_TIME_RST;
    settle_ticks = INTERVAL_RST;
    pressed      = 1'b0;
    press_at     = '0;
    settle_from  = '0;
    held_now     = '0;
    fails        = 0;
  endfunction

  // A register write; rewriting the active level forgets any press.
  function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    case (idx)
      REG_ACTIVE_LEVEL: begin
        act_level = data[0];
        pressed   = 1'b0;
      end
      REG_HOLD_TIME:         hold_ticks   = data;
      REG_DEBOUNCE_INTERVAL: settle_ticks = data;
      default: ;
    endcase
  endfunction

  // Works out the status beat caused by one accepted sample.
  function void note_sample(logic lvl, logic [DATA_W-1:0] stamp);
    bit                active;
    status_t           st;
    result_t           beat;
    logic [DATA_W-1:0] since;
    logic [DATA_W-1:0] thresh;
    active = (lvl == act_level);
    st     = ST_WAITING;
    if (active && !pressed) begin
      settle_from = stamp;
      press_at    = stamp;
      pressed     = 1'b1;
      st          = ST_PRESSED;
    end
    since = stamp - settle_from;
    if (since >= settle_ticks) begin
      held_now = '0;
      if (active && pressed) begin
        // A timestamp behind the press means time has wrapped.
        if (stamp < press_at) press_at = '0;
        held_now = stamp - press_at;
        thresh   = hold_ticks - settle_ticks;
        if (held_now >= thresh) st = ST_HELD;
      end
      if (!active && pressed) begin
        st      = ST_RELEASED;
        pressed = 1'b0;
      end
    end
    beat.status = st;
    beat.held   = held_now;
    due_q.push_back(beat);
  endfunction

  function void report(string what);
    fails++;
    if (fails <= 10) $display("%0t: mismatch: %s", $time, what);
  endfunction

  // Compares one status beat with the oldest one owed.
  function void check_result(logic [1:0] st, logic [DATA_W-1:0] held);
    result_t beat;
    if (due_q.size() == 0) begin
      report($sformatf("unexpected beat status=%0d held=%0d", st, held));
      return;
    end
    beat = due_q.pop_front();
    if (beat.status != st || beat.held != held)
      report($sformatf("status exp %0d got %0d, held exp %0d got %0d",
                       beat.status, st, beat.held, held));
  endfunction

  function int unsigned outstanding();
    return due_q.size();
  endfunction
endclass

module button_press_hold_release_core_tb;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_SAMPLES = 1400;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic                 level;
  logic [DATA_W-1:0]    now;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           status;
  logic [DATA_W-1:0]    held_ticks;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  detector_scoreboard sb = new();
  int unsigned        samples_sent;
  bit                 calm;

  button_press_hold_release_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .level      (level),
    .now        (now),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .held_ticks (held_ticks),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog for a hung handshake.
  initial begin
    #8000000;
    $display("button_press_hold_release_core verification failed");
    $finish;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Sends one sample beat and holds it until accepted.
  task automatic send_sample(logic lvl, logic [DATA_W-1:0] stamp);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    level    <= lvl;
    now      <= stamp;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(lvl, stamp);
    samples_sent++;
  endtask

  // Stops sending until every owed beat has arrived.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.apply_reg(idx, data);
  endtask

  // Next timestamp: mostly small steps, sometimes jumps back or anywhere.
  function automatic logic [DATA_W-1:0] next_stamp(logic [DATA_W-1:0] t);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return t + $urandom_range(0, 6);
    if (r < 93) return t + $urandom_range(7, 40);
    if (r < 97) return t - $urandom_range(1, 20);
    return $urandom;
  endfunction

  // One press, hold and release sequence with the odd bounce.
  task automatic press_episode();
    logic [DATA_W-1:0] t;
    logic              act;
    int                r;
    act = sb.act_level;
    r = $urandom_range(0, 99);
    if (r < 70) t = $urandom;
    else if (r < 85) t = 32'hFFFF_FFFF - $urandom_range(0, 40);
    else t = $urandom_range(0, 20);
    repeat ($urandom_range(0, 2)) begin
      send_sample(~act, t);
      t = t + $urandom_range(0, 3);
    end
    repeat ($urandom_range(1, 24)) begin
      if ($urandom_range(0, 19) == 0) send_sample(~act, t);
      else send_sample(act, t);
      t = next_stamp(t);
    end
    repeat ($urandom_range(1, 3)) begin
      send_sample(~act, t);
      t = next_stamp(t);
    end
  endtask

  // New register settings for a random phase; the first three are extremes.
  task automatic random_setup(int unsigned phase);
    logic [DATA_W-1:0] ht;
    logic [DATA_W-1:0] di;
    int                r;
    case (phase)
      0: begin ht = '0;           di = 32'hFFFF_FFFF; end
      1: begin ht = 32'hFFFF_FFFF; di = '0;          end
      2: begin ht = 32'hFFFF_FFFF; di = 32'hFFFF_FFFF; end
      default: begin
        r = $urandom_range(0, 9);
        if (r < 7) ht = $urandom_range(0, 80);
        else if (r < 9) ht = $urandom;
        else ht = '0;
        r = $urandom_range(0, 9);
        if (r < 6) di = $urandom_range(0, 10);
        else if (r < 8) di = '0;
        else if (r < 9) di = $urandom;
        else di = 32'hFFFF_FFFF;
      end
    endcase
    write_reg(REG_HOLD_TIME, ht);
    write_reg(REG_DEBOUNCE_INTERVAL, di);
    if ($urandom_range(0, 1) == 1) write_reg(REG_ACTIVE_LEVEL, $urandom);
    if ($urandom_range(0, 5) == 0) write_reg(REG_UNUSED, $urandom);
    calm = ($urandom_range(0, 3) == 0);
  endtask

  // Result side back-pressure.
  initial begin
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      n = idle_len();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Result beat monitor.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(status, held_ticks);
  end

  // Main stimulus sequence.
  initial begin
    int unsigned phase;
    int unsigned phase_end;
    int unsigned target;
    int          r;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    level     <= 1'b0;
    now       <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ACTIVE_LEVEL;
    cfg_data  <= '0;
    calm       = 1'b0;
    samples_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: press, hold, wrap behind the press and release.
    send_sample(1'b0, 32'h0);
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b1, 32'd100);
    send_sample(1'b1, 32'd599);
    send_sample(1'b1, 32'd600);
    send_sample(1'b1, 32'd50);
    send_sample(1'b1, 32'hFFFF_FFFF);
    send_sample(1'b0, 32'd7);
    send_sample(1'b0, 32'd8);

    // Hold time below the debounce interval, so the threshold wraps.
    write_reg(REG_DEBOUNCE_INTERVAL, 32'd10);
    write_reg(REG_HOLD_TIME, 32'd5);
    send_sample(1'b1, 32'd1000);
    send_sample(1'b0, 32'd1005);
    send_sample(1'b1, 32'd1009);
    send_sample(1'b1, 32'd1010);
    send_sample(1'b0, 32'd1020);

    // Ordinary hold, then a rewrite of the active level mid-press.
    write_reg(REG_HOLD_TIME, 32'd20);
    send_sample(1'b1, 32'd2000);
    send_sample(1'b1, 32'd2010);
    write_reg(REG_ACTIVE_LEVEL, 32'hFFFF_FFFF);
    send_sample(1'b1, 32'd2011);

    // Active low with a zero threshold; an unknown index changes nothing.
    write_reg(REG_ACTIVE_LEVEL, 32'hFFFF_FFFE);
    write_reg(REG_DEBOUNCE_INTERVAL, 32'd0);
    write_reg(REG_HOLD_TIME, 32'd0);
    send_sample(1'b0, 32'h0);
    send_sample(1'b1, 32'd5);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b1, 32'hFFFF_FFFF);

    // Random phases of press sequences and noise.
    phase     = 0;
    target    = samples_sent + RANDOM_SAMPLES;
    phase_end = samples_sent;
    while (samples_sent < target) begin
      if (samples_sent >= phase_end) begin
        random_setup(phase);
        phase++;
        phase_end = samples_sent + $urandom_range(60, 140);
      end
      r = $urandom_range(0, 99);
      if (r < 80) press_episode();
      else if (r < 96) send_sample(1'($urandom_range(0, 1)), $urandom);
      else wait_idle();
    end

    // Drain and give the verdict.
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.fails == 0 && sb.outstanding() == 0) begin
      $display("button_press_hold_release_core verification clean");
    end else begin
      $display("button_press_hold_release_core verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/bphr_pkg.sv
hw/rtl/bphr_in_reg.sv
hw/rtl/bphr_eval.sv
hw/rtl/bphr_out_reg.sv
hw/rtl/button_press_hold_release_core.sv
sim/button_press_hold_release_core_tb.sv
